// File: rtl/assert_macros.svh
// assertion helpers, compiled out with ASSERT_OFF
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER_AT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER_AT(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/salc_pkg.sv
package salc_pkg;

  localparam int MAX_SETS  = 256;
  localparam int MAX_WAYS  = 8;
  localparam int STAMP_W   = 32;

  localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
  localparam int IDX_MAX   = $clog2(MAX_SETS + 1) - 1;
  localparam int PAIRS     = (MAX_WAYS + 1) / 2;

  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 32;
  localparam int NUM_W     = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int SETO_W    = 8;
  localparam int WAYO_W    = 3;
  localparam int PEN_W     = 8;
  localparam int SHAMT_W   = 6;

  localparam int MISS_COST = 100;
  localparam logic [PEN_W-1:0] PEN_HIT   = '0;
  localparam logic [PEN_W-1:0] PEN_CLEAN = PEN_W'(1 + MISS_COST);
  localparam logic [PEN_W-1:0] PEN_DIRTY = PEN_W'(1 + 2 * MISS_COST);

  localparam logic [CFG_W-1:0] OFFSET_RST = CFG_W'(6);
  localparam logic [CFG_W-1:0] INDEX_RST  = CFG_W'(6);
  localparam logic [CFG_W-1:0] WAYS_RST   = CFG_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET = 2'd0,
    CFG_INDEX  = 2'd1,
    CFG_WAYS   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUT_HIT        = 2'd0,
    OUT_MISS_CLEAN = 2'd1,
    OUT_MISS_DIRTY = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               valid;
    logic               dirty;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef entry_t [MAX_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic               en;
    logic [STAMP_W-1:0] stamp;
    logic [WAY_W-1:0]   way;
  } cand_t;

endpackage

// File: rtl/salc_ram.sv
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/set_assoc_lru_writeback_cache.sv
// Tag store of a set-associative write-back write-allocate cache with LRU by stamp.
// Input channel (in_valid_i / in_stall_o): req_type_i, address_i, access_number_i.
// Output channel (out_valid_o / out_stall_i): one result per access, with the
// outcome, set, tag, way used, the way's previous tag/valid/dirty/stamp and penalty.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 offset bits, 1 index bits, 2 ways in use); write only while idle.
// Each access reads the whole set row from the row memory, then does the tag compares
// and the first registered level of the oldest-stamp tree, then finishes the tree,
// writes the row back and loads the result.
// A new access is taken only after the previous row write, so back-to-back
// accesses to the same set need no forwarding; no new access is taken while one
// is still in progress.
// The result sits in an output register; while the receiver stalls the next access
// is still taken and runs up to its write-back, where it waits for the register.
// Reset clears one valid flag per set row in flip-flops; a row never written reads
// as all ways invalid with zero tags and stamps, so there is no clearing pass.
module set_assoc_lru_writeback_cache
  import salc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 req_type_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic [NUM_W-1:0]     access_number_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           outcome_o,
  output logic [SETO_W-1:0]    set_index_o,
  output logic [TAG_W-1:0]     tag_value_o,
  output logic [WAYO_W-1:0]    way_used_o,
  output logic [TAG_W-1:0]     old_tag_o,
  output logic                 old_valid_o,
  output logic                 old_dirty_o,
  output logic [NUM_W-1:0]     old_stamp_o,
  output logic [PEN_W-1:0]     miss_penalty_o
);

`include "assert_macros.svh"

  logic [CFG_W-1:0] offset_q, offset_d;
  logic [CFG_W-1:0] index_q, index_d;
  logic [CFG_W-1:0] ways_q, ways_d;

  always_comb begin
    offset_d = offset_q;
    index_d  = index_q;
    ways_d   = ways_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_OFFSET: offset_d = cfg_data_i;
        CFG_INDEX:  index_d  = cfg_data_i;
        CFG_WAYS:   ways_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RST;
      index_q  <= INDEX_RST;
      ways_q   <= WAYS_RST;
    end else begin
      offset_q <= offset_d;
      index_q  <= index_d;
      ways_q   <= ways_d;
    end
  end

  logic [CFG_W-1:0]  eff_ib;
  logic [WCNT_W-1:0] eff_ways;

  always_comb begin
    eff_ib = (int'(index_q) > IDX_MAX) ? CFG_W'(IDX_MAX) : index_q;
    if (ways_q == '0) begin
      eff_ways = WCNT_W'(1);
    end else if (int'(ways_q) > MAX_WAYS) begin
      eff_ways = WCNT_W'(MAX_WAYS);
    end else begin
      eff_ways = WCNT_W'(ways_q);
    end
  end

  // address split
  logic [SHAMT_W-1:0] tag_shamt;
  logic [ADDR_W-1:0]  set_mask;
  logic [SET_W-1:0]   set_d;
  logic [TAG_W-1:0]   tag_d;

  assign tag_shamt = SHAMT_W'(offset_q) + SHAMT_W'(eff_ib);
  assign set_mask  = (ADDR_W'(1) << eff_ib) - ADDR_W'(1);
  assign set_d     = SET_W'((address_i >> offset_q) & set_mask);
  assign tag_d     = TAG_W'(address_i >> tag_shamt);

  // control
  state_e state_q, state_d;
  logic   in_acc;
  logic   out_load;
  logic   sel_en;
  logic   upd_en;
  logic   out_valid_q, out_valid_d;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SEL;
      ST_SEL:  state_d = ST_UPD;
      ST_UPD:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    sel_en     = 1'b0;
    upd_en     = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_SEL:  sel_en     = 1'b1;
      ST_UPD:  upd_en     = out_load;
      default: ;
    endcase
  end

  assign out_valid_d = upd_en || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request registers
  logic               wr_q;
  logic [SET_W-1:0]   set_q;
  logic [TAG_W-1:0]   tag_q;
  logic [STAMP_W-1:0] stamp_q;
  logic               rv_q;
  logic [MAX_SETS-1:0] row_vld_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wr_q    <= req_type_i;
      set_q   <= set_d;
      tag_q   <= tag_d;
      stamp_q <= STAMP_W'(access_number_i);
      rv_q    <= row_vld_q[set_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (upd_en) begin
      row_vld_q[set_q] <= 1'b1;
    end
  end

  // set row memory
  logic [ROW_W-1:0] ram_rdata;
  row_t             row;
  row_t             row_new;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (upd_en),
    .waddr_i (set_q),
    .wdata_i (row_new),
    .re_i    (in_acc),
    .raddr_i (set_d),
    .rdata_o (ram_rdata)
  );

  assign row = rv_q ? row_t'(ram_rdata) : '0;

  // compare and first level of the oldest-stamp tree
  logic             hit_d, hit_q;
  logic [WAY_W-1:0] hit_way_d, hit_way_q;
  logic             inv_d, inv_q;
  logic [WAY_W-1:0] inv_way_d, inv_way_q;
  cand_t            cand_d [PAIRS];
  cand_t            cand_q [PAIRS];

  always_comb begin
    hit_d     = 1'b0;
    hit_way_d = '0;
    inv_d     = 1'b0;
    inv_way_d = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w < eff_ways) begin
        if (!hit_d && row[WAY_W'(w)].valid && row[WAY_W'(w)].tag == tag_q) begin
          hit_d     = 1'b1;
          hit_way_d = WAY_W'(w);
        end
        if (!inv_d && !row[WAY_W'(w)].valid) begin
          inv_d     = 1'b1;
          inv_way_d = WAY_W'(w);
        end
      end
    end
    for (int p = 0; p < PAIRS; p++) begin
      cand_d[p].en    = (2 * p) < eff_ways;
      cand_d[p].stamp = row[WAY_W'(2 * p)].stamp;
      cand_d[p].way   = WAY_W'(2 * p);
      if (2 * p + 1 < MAX_WAYS) begin
        if ((2 * p + 1) < eff_ways &&
            row[WAY_W'(2 * p + 1)].stamp < row[WAY_W'(2 * p)].stamp) begin
          cand_d[p].stamp = row[WAY_W'(2 * p + 1)].stamp;
          cand_d[p].way   = WAY_W'(2 * p + 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel_en) begin
      hit_q     <= hit_d;
      hit_way_q <= hit_way_d;
      inv_q     <= inv_d;
      inv_way_q <= inv_way_d;
      cand_q    <= cand_d;
    end
  end

  // victim choice, row update and result
  cand_t            best;
  logic [WAY_W-1:0] way;
  entry_t           ent;
  entry_t           ent_new;
  logic             victim_dirty;
  outcome_e         outcome_d;

  always_comb begin
    best = cand_q[0];
    for (int i = 1; i < PAIRS; i++) begin
      if (cand_q[i].en && cand_q[i].stamp < best.stamp) begin
        best = cand_q[i];
      end
    end
    if (hit_q) begin
      way = hit_way_q;
    end else if (inv_q) begin
      way = inv_way_q;
    end else begin
      way = best.way;
    end
    ent          = row[way];
    victim_dirty = ent.valid && ent.dirty;
    ent_new.tag   = tag_q;
    ent_new.valid = 1'b1;
    ent_new.stamp = stamp_q;
    if (hit_q) begin
      ent_new.dirty = ent.dirty || wr_q;
      outcome_d     = OUT_HIT;
    end else begin
      ent_new.dirty = wr_q;
      outcome_d     = victim_dirty ? OUT_MISS_DIRTY : OUT_MISS_CLEAN;
    end
    row_new      = row;
    row_new[way] = ent_new;
  end

  logic [1:0]          outcome_q;
  logic [SETO_W-1:0]   set_out_q;
  logic [TAG_W-1:0]    tag_out_q;
  logic [WAYO_W-1:0]   way_out_q;
  logic [TAG_W-1:0]    old_tag_q;
  logic                old_valid_q;
  logic                old_dirty_q;
  logic [NUM_W-1:0]    old_stamp_q;
  logic [PEN_W-1:0]    penalty_q;

  always_ff @(posedge clk_i) begin
    if (upd_en) begin
      outcome_q   <= outcome_d;
      set_out_q   <= SETO_W'(set_q);
      tag_out_q   <= tag_q;
      way_out_q   <= WAYO_W'(way);
      old_tag_q   <= ent.valid ? ent.tag : '0;
      old_valid_q <= ent.valid;
      old_dirty_q <= victim_dirty;
      old_stamp_q <= NUM_W'(ent.stamp);
      if (hit_q) begin
        penalty_q <= PEN_HIT;
      end else begin
        penalty_q <= victim_dirty ? PEN_DIRTY : PEN_CLEAN;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign outcome_o      = outcome_q;
  assign set_index_o    = set_out_q;
  assign tag_value_o    = tag_out_q;
  assign way_used_o     = way_out_q;
  assign old_tag_o      = old_tag_q;
  assign old_valid_o    = old_valid_q;
  assign old_dirty_o    = old_dirty_q;
  assign old_stamp_o    = old_stamp_q;
  assign miss_penalty_o = penalty_q;

  `ASSERT_AT(a_row_marked_after_write, clk_i, rst_ni,
             upd_en |=> row_vld_q[$past(set_q)], "row written back but not marked valid")
  `ASSERT_AT(a_dirty_miss_fields, clk_i, rst_ni,
             (out_valid_o && outcome_o == OUT_MISS_DIRTY) |->
             (old_valid_o && old_dirty_o && miss_penalty_o == PEN_DIRTY),
             "dirty miss result inconsistent")
  `ASSERT_AT(a_sel_follows_transfer, clk_i, rst_ni,
             (state_q == ST_SEL) |-> $past(in_valid_i && !in_stall_o),
             "compare stage entered without an input transfer")

endmodule

// File: verif/tb_top.sv
import salc_pkg::*;

typedef struct {
  outcome_e    outcome;
  logic [7:0]  set_idx;
  logic [31:0] tag;
  logic [2:0]  way;
  logic [31:0] old_tag;
  logic        old_valid;
  logic        old_dirty;
  logic [31:0] old_stamp;
  logic [7:0]  penalty;
} lookup_t;

class tag_store_scoreboard;
  logic [TAG_W-1:0]   line_tag   [MAX_SETS*MAX_WAYS];
  logic               line_valid [MAX_SETS*MAX_WAYS];
  logic               line_dirty [MAX_SETS*MAX_WAYS];
  logic [STAMP_W-1:0] line_stamp [MAX_SETS*MAX_WAYS];
  logic [3:0]         off_bits;
  logic [3:0]         idx_bits;
  logic [3:0]         way_cnt;
  lookup_t            pending_lookups [$];
  int                 errors;

  function new();
    for (int i = 0; i < MAX_SETS * MAX_WAYS; i++) begin
      line_tag[i]   = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_stamp[i] = '0;
    end
    off_bits = OFFSET_RST;
    idx_bits = INDEX_RST;
    way_cnt  = WAYS_RST;
    errors   = 0;
  endfunction

  function void set_config(logic [3:0] o, logic [3:0] i, logic [3:0] w);
    off_bits = o;
    idx_bits = i;
    way_cnt  = w;
  endfunction

  function int pending();
    return pending_lookups.size();
  endfunction

  function void note_access(logic is_wr, logic [31:0] addr, logic [31:0] num);
    int unsigned ib, ways, sh, set_no, base, hit, vic, e;
    logic [31:0] tg;
    logic        victim_dirty;
    lookup_t     r;
    ib     = (idx_bits > IDX_MAX) ? IDX_MAX : idx_bits;
    ways   = (way_cnt == 0) ? 1 : ((way_cnt > MAX_WAYS) ? MAX_WAYS : way_cnt);
    sh     = off_bits + ib;
    set_no = (addr >> off_bits) & ((32'd1 << ib) - 1);
    tg     = addr >> sh;
    base   = set_no * MAX_WAYS;
    hit    = ways;
    for (int unsigned w = 0; w < ways; w++) begin
      if (line_valid[base + w] && line_tag[base + w] == tg) begin
        hit = w;
        break;
      end
    end
    r.set_idx = set_no[7:0];
    r.tag     = tg;
    if (hit < ways) begin
      e           = base + hit;
      r.outcome   = OUT_HIT;
      r.way       = hit[2:0];
      r.old_tag   = line_tag[e];
      r.old_valid = 1'b1;
      r.old_dirty = line_dirty[e];
      r.old_stamp = line_stamp[e];
      r.penalty   = PEN_HIT;
      line_stamp[e] = num;
      if (is_wr) line_dirty[e] = 1'b1;
    end else begin
      vic = ways;
      for (int unsigned w = 0; w < ways; w++) begin
        if (!line_valid[base + w]) begin
          vic = w;
          break;
        end
      end
      if (vic == ways) begin
        vic = 0;
        for (int unsigned w = 1; w < ways; w++)
          if (line_stamp[base + w] < line_stamp[base + vic]) vic = w;
      end
      e            = base + vic;
      victim_dirty = line_valid[e] && line_dirty[e];
      r.outcome    = victim_dirty ? OUT_MISS_DIRTY : OUT_MISS_CLEAN;
      r.way        = vic[2:0];
      r.old_tag    = line_valid[e] ? line_tag[e] : '0;
      r.old_valid  = line_valid[e];
      r.old_dirty  = victim_dirty;
      r.old_stamp  = line_stamp[e];
      r.penalty    = victim_dirty ? PEN_DIRTY : PEN_CLEAN;
      line_tag[e]   = tg;
      line_valid[e] = 1'b1;
      line_dirty[e] = is_wr;
      line_stamp[e] = num;
    end
    pending_lookups.push_back(r);
  endfunction

  function void cmp_field(string fname, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t %s mismatch: expected %0h actual %0h", $time, fname, e, a);
    end
  endfunction

  function void check_result(lookup_t act);
    lookup_t x;
    if (pending_lookups.size() == 0) begin
      errors++;
      $display("%0t unexpected result: expected none actual set %0h tag %0h",
               $time, act.set_idx, act.tag);
      return;
    end
    x = pending_lookups.pop_front();
    cmp_field("outcome", 32'(x.outcome), 32'(act.outcome));
    cmp_field("set_index", 32'(x.set_idx), 32'(act.set_idx));
    cmp_field("tag_value", x.tag, act.tag);
    cmp_field("way_used", 32'(x.way), 32'(act.way));
    cmp_field("old_tag", x.old_tag, act.old_tag);
    cmp_field("old_valid", 32'(x.old_valid), 32'(act.old_valid));
    cmp_field("old_dirty", 32'(x.old_dirty), 32'(act.old_dirty));
    cmp_field("old_stamp", x.old_stamp, act.old_stamp);
    cmp_field("miss_penalty", 32'(x.penalty), 32'(act.penalty));
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 300000;
  localparam int N_PHASES    = 9;
  localparam int PHASE_ITEMS = 95;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_OFFSET;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 req_type_i = 1'b0;
  logic [ADDR_W-1:0]    address_i = '0;
  logic [NUM_W-1:0]     access_number_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [1:0]           outcome_o;
  logic [SETO_W-1:0]    set_index_o;
  logic [TAG_W-1:0]     tag_value_o;
  logic [WAYO_W-1:0]    way_used_o;
  logic [TAG_W-1:0]     old_tag_o;
  logic                 old_valid_o;
  logic                 old_dirty_o;
  logic [NUM_W-1:0]     old_stamp_o;
  logic [PEN_W-1:0]     miss_penalty_o;

  tag_store_scoreboard sb;
  int unsigned         cycles = 0;
  bit                  long_hold = 1'b0;
  logic [3:0]          cur_off = OFFSET_RST;
  logic [3:0]          cur_idx = INDEX_RST;
  logic [3:0]          cur_ways = WAYS_RST;
  logic [31:0]         acc_num = 32'd100;

  set_assoc_lru_writeback_cache uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    lookup_t act;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act.outcome   = outcome_e'(outcome_o);
      act.set_idx   = set_index_o;
      act.tag       = tag_value_o;
      act.way       = way_used_o;
      act.old_tag   = old_tag_o;
      act.old_valid = old_valid_o;
      act.old_dirty = old_dirty_o;
      act.old_stamp = old_stamp_o;
      act.penalty   = miss_penalty_o;
      sb.check_result(act);
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : rx_proc
    int unsigned pct;
    pct = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall_i <= 1'b1;
        for (int n = 0; n < 300; n++) @(posedge clk_i);
      end
      if (($urandom % 48) == 0) begin
        case ($urandom_range(3))
          0: pct = 0;
          1: pct = 25;
          2: pct = 50;
          default: pct = 85;
        endcase
      end
      out_stall_i <= ($urandom_range(99) < pct);
    end
  end

  task automatic send_item(logic is_wr, logic [31:0] addr, logic [31:0] num);
    in_valid_i      <= 1'b1;
    req_type_i      <= is_wr;
    address_i       <= addr;
    access_number_i <= num;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_access(is_wr, addr, num);
  endtask

  task automatic idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [3:0] o, logic [3:0] i, logic [3:0] w);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_OFFSET;
    cfg_data_i <= o;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INDEX;
    cfg_data_i <= i;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_WAYS;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_config(o, i, w);
    cur_off  = o;
    cur_idx  = i;
    cur_ways = w;
    @(posedge clk_i);
  endtask

  task automatic run_random(int count);
    int unsigned ib, sh, ways, pool, span, burst, gap, tg, st;
    logic [31:0] tag_base, addr, num;
    bit          no_gaps;
    int          sent;
    ib       = (cur_idx > IDX_MAX) ? IDX_MAX : cur_idx;
    sh       = cur_off + ib;
    ways     = (cur_ways == 0) ? 1 : ((cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways);
    pool     = $urandom_range(2 * ways + 3, 2);
    span     = ((1 << ib) < 4) ? (1 << ib) : 4;
    tag_base = $urandom_range(1) ? 32'd0 : $urandom;
    sent     = 0;
    no_gaps  = 1'b0;
    while (sent < count) begin
      burst = $urandom_range(16, 1);
      if ($urandom_range(5) == 0) no_gaps = !no_gaps;
      for (int unsigned b = 0; b < burst && sent < count; b++) begin
        if ($urandom_range(99) < 12) begin
          addr = $urandom;
        end else begin
          tg   = tag_base + $urandom_range(pool - 1);
          st   = ($urandom_range(9) == 0) ? $urandom_range((1 << ib) - 1)
                                          : $urandom_range(span - 1);
          addr = (32'(tg) << sh) | (32'(st) << cur_off) |
                 ($urandom & ((32'd1 << cur_off) - 1));
        end
        if ($urandom_range(19) == 0) begin
          num = $urandom;
        end else begin
          acc_num = acc_num + $urandom_range(3);
          num     = acc_num;
        end
        send_item(1'($urandom_range(1)), addr, num);
        sent++;
      end
      gap = no_gaps ? 0 : $urandom_range(4);
      if (gap > 0) idle_cycles(gap);
    end
  endtask

  initial begin : stim_proc
    logic [3:0] phase_cfg [N_PHASES][3];
    sb = new();
    phase_cfg = '{'{0, 0, 1}, '{12, 8, 8}, '{3, 2, 4}, '{15, 15, 15}, '{0, 0, 0},
                  '{5, 3, 3}, '{2, 1, 8}, '{9, 4, 2}, '{4, 0, 8}};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_item(1'b0, 32'h0000_0000, 32'd1);
    send_item(1'b0, 32'h0000_003F, 32'd2);
    send_item(1'b1, 32'h0000_0000, 32'd3);
    send_item(1'b1, 32'hFFFF_FFFF, 32'd4);
    send_item(1'b0, 32'hFFFF_FFC0, 32'hFFFF_FFFF);
    for (int k = 1; k <= 7; k++)
      send_item(k[0], 32'(k) << 12, 32'(4 + k));
    // set 0 full: next miss evicts the oldest, which is dirty
    send_item(1'b0, 32'h0000_8000, 32'd20);
    send_item(1'b0, 32'h0000_0000, 32'd21);
    send_item(1'b0, 32'h0000_8000, 32'd22);
    send_item(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
    send_item(1'b1, 32'hAAAA_AAAA, 32'h5555_5555);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_cfg(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
      if (p == 2) long_hold = 1'b1;
      run_random(PHASE_ITEMS);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/set_assoc_lru_writeback_cache.sv
verif/tb_top.sv
